// ----- rtl/core/mexp_pkg.sv -----
// Shared types and command codes for the modular exponentiation block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mexp_pkg;

    typedef logic [3:0] t_op;

    localparam t_op OP_NOP      = 4'd0;
    localparam t_op OP_LOAD     = 4'd1;
    localparam t_op OP_SET_ONE  = 4'd2;
    localparam t_op OP_LD_ONE   = 4'd3;
    localparam t_op OP_LD_MSG   = 4'd4;
    localparam t_op OP_MUL_SQ   = 4'd5;
    localparam t_op OP_MUL_BASE = 4'd6;
    localparam t_op OP_RED      = 4'd7;
    localparam t_op OP_WR_ACC   = 4'd8;
    localparam t_op OP_WR_BASE  = 4'd9;
    localparam t_op OP_SHIFT    = 4'd10;
    localparam t_op OP_OUT      = 4'd11;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXPONENT = 2'd0;
    localparam logic [1:0] CFG_MODULUS  = 2'd1;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic exp_zero;
        logic mod_zero;
        logic exp_msb;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/core/mexp_dp.sv -----
// Datapath: configuration registers, operand registers, one shared multiplier
// and a two-bit-per-cycle shift-subtract reducer. Depends on mexp_pkg.
`default_nettype none

module mexp_dp #(
    parameter int WORD_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [1:0]            i_cfg_index,
    input  wire  [WORD_BITS-1:0]  i_cfg_data,
    input  wire  [WORD_BITS-1:0]  i_message,
    input  mexp_pkg::t_cmd        i_cmd,
    output mexp_pkg::t_status     o_status,
    output logic [WORD_BITS-1:0]  o_result
);
    import mexp_pkg::*;

    localparam int PW = 2 * WORD_BITS;

    logic [WORD_BITS-1:0] r_exponent;
    logic [WORD_BITS-1:0] r_modulus;
    logic [WORD_BITS-1:0] r_exp;
    logic [WORD_BITS-1:0] r_mod;
    logic [WORD_BITS-1:0] r_msg;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_base;
    logic [PW-1:0]        r_prod;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_result;

    logic [WORD_BITS-1:0] w_mul_b;
    logic [PW-1:0]        w_mul;
    logic [WORD_BITS:0]   w_r1;
    logic [WORD_BITS:0]   w_r1s;
    logic [WORD_BITS:0]   w_r2;
    logic [WORD_BITS:0]   w_r2s;
    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] w_wr_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= WORD_BITS'(1);
            r_modulus  <= '1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_EXPONENT) begin
                r_exponent <= i_cfg_data;
            end else if (i_cfg_index == CFG_MODULUS) begin
                r_modulus <= i_cfg_data;
            end
        end
    end

    assign w_mul_b = (i_cmd.op == OP_MUL_BASE) ? r_base : r_acc;
    assign w_mul   = r_acc * w_mul_b;

    // Two restoring steps per cycle; the remainder always stays below the modulus.
    always_comb begin
        w_r1  = {r_rem, r_prod[PW-1]};
        w_r1s = (w_r1 >= {1'b0, r_mod}) ? (w_r1 - {1'b0, r_mod}) : w_r1;
        w_r2  = {w_r1s[WORD_BITS-1:0], r_prod[PW-2]};
        w_r2s = (w_r2 >= {1'b0, r_mod}) ? (w_r2 - {1'b0, r_mod}) : w_r2;
        n_rem = w_r2s[WORD_BITS-1:0];
    end

    // A zero modulus means plain truncation; the reducer is then skipped.
    assign w_wr_val = (r_mod == '0) ? r_prod[WORD_BITS-1:0] : r_rem;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op) inside
            OP_LOAD: begin
                r_exp <= r_exponent;
                r_mod <= r_modulus;
                r_msg <= i_message;
            end
            OP_SET_ONE:  r_acc <= WORD_BITS'(1);
            OP_LD_ONE: begin
                r_prod <= PW'(1);
                r_rem  <= '0;
            end
            OP_LD_MSG: begin
                r_prod <= {{WORD_BITS{1'b0}}, r_msg};
                r_rem  <= '0;
            end
            OP_MUL_SQ, OP_MUL_BASE: begin
                r_prod <= w_mul;
                r_rem  <= '0;
            end
            OP_RED: begin
                r_prod <= {r_prod[PW-3:0], 2'b00};
                r_rem  <= n_rem;
            end
            OP_WR_ACC:   r_acc    <= w_wr_val;
            OP_WR_BASE:  r_base   <= w_wr_val;
            OP_SHIFT:    r_exp    <= {r_exp[WORD_BITS-2:0], 1'b0};
            OP_OUT:      r_result <= r_acc;
            default: begin
            end
        endcase
    end

    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.mod_zero = (r_mod == '0);
    assign o_status.exp_msb  = r_exp[WORD_BITS-1];
    assign o_result          = r_result;

endmodule

`default_nettype wire

// ----- rtl/core/mexp_ctrl.sv -----
// Controller: sequences square-and-multiply over the exponent bits and the
// reduction steps of each product, and owns the handshakes. Depends on mexp_pkg.
`default_nettype none

module mexp_ctrl #(
    parameter int WORD_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire                i_stall,
    input  mexp_pkg::t_status  i_status,
    output mexp_pkg::t_cmd     o_cmd
);
    import mexp_pkg::*;

    localparam int CW = $clog2(WORD_BITS);
    localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_RED   = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_NEXT  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [1:0] PH_ONE = 2'd0;
    localparam logic [1:0] PH_MSG = 2'd1;
    localparam logic [1:0] PH_SQ  = 2'd2;
    localparam logic [1:0] PH_MB  = 2'd3;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_red_cnt, n_red_cnt;
    logic [CW-1:0] r_bit_cnt, n_bit_cnt;
    logic          r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_red_cnt   = r_red_cnt;
        n_bit_cnt   = r_bit_cnt;
        n_out_valid = r_out_valid && i_stall;
        o_cmd.op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op  = OP_LOAD;
                    n_bit_cnt = '0;
                    n_state   = S_START;
                end
            end
            S_START: begin
                if (i_status.exp_zero) begin
                    o_cmd.op = OP_SET_ONE;
                    n_state  = S_FIN;
                end else begin
                    n_phase = PH_ONE;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                unique case (r_phase)
                    PH_ONE:  o_cmd.op = OP_LD_ONE;
                    PH_MSG:  o_cmd.op = OP_LD_MSG;
                    PH_SQ:   o_cmd.op = OP_MUL_SQ;
                    default: o_cmd.op = OP_MUL_BASE;
                endcase
                n_red_cnt = '0;
                n_state   = i_status.mod_zero ? S_WR : S_RED;
            end
            S_RED: begin
                o_cmd.op = OP_RED;
                if (r_red_cnt == LAST) begin
                    n_state = S_WR;
                end else begin
                    n_red_cnt = r_red_cnt + 1'b1;
                end
            end
            S_WR: begin
                o_cmd.op = (r_phase == PH_MSG) ? OP_WR_BASE : OP_WR_ACC;
                unique case (r_phase)
                    PH_ONE: begin
                        n_phase = PH_MSG;
                        n_state = S_MUL;
                    end
                    PH_MSG: begin
                        n_phase = PH_SQ;
                        n_state = S_MUL;
                    end
                    PH_SQ: begin
                        if (i_status.exp_msb) begin
                            n_phase = PH_MB;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_NEXT;
                        end
                    end
                    default: n_state = S_NEXT;
                endcase
            end
            S_NEXT: begin
                o_cmd.op = OP_SHIFT;
                if (r_bit_cnt == LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_bit_cnt = r_bit_cnt + 1'b1;
                    n_phase   = PH_SQ;
                    n_state   = S_MUL;
                end
            end
            S_FIN: begin
                // The output register is free or its word leaves this cycle.
                if (!r_out_valid || !i_stall) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ONE;
            r_red_cnt   <= '0;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_red_cnt   <= n_red_cnt;
            r_bit_cnt   <= n_bit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/core/modular_exponentiation_top.sv -----
// Top level of the modular exponentiation block: controller plus datapath.
// Depends on mexp_pkg, mexp_ctrl and mexp_dp.
//
// Usage: load the exponent (index 0) and modulus (index 1) through the
// configuration channel while the block is idle; o_cfg_ready is always high.
// Each word on the input channel (i_valid, o_stall, i_message) yields one word
// on the output channel (o_valid, i_stall, o_result): message to the exponent
// modulo the modulus, or 1 when the exponent is zero.
// Each modular product is one multiplier step, WORD_BITS reduction steps of
// two bits each and one write-back, and each exponent bit adds a shift step.
// A zero modulus skips the reduction steps. One item is worked on at a time;
// the next is accepted as soon as the previous result sits in the output
// register. Reset returns the exponent to 1, the modulus to all ones, and
// empties the output register. While the receiver stalls, o_result holds and
// a finished item waits in the controller until the output register frees up.
`default_nettype none

module modular_exponentiation_top #(
    parameter int WORD_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire  [WORD_BITS-1:0]  i_message,
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic [WORD_BITS-1:0]  o_result,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [1:0]            i_cfg_index,
    input  wire  [WORD_BITS-1:0]  i_cfg_data
);
    import mexp_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    mexp_ctrl #(
        .WORD_BITS(WORD_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mexp_dp #(
        .WORD_BITS(WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_message   (i_message),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/mexp_checker.sv -----
// Port-level checks for the modular exponentiation block, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module mexp_checker #(
    parameter int WORD_BITS = 16
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_valid,
    input wire                  o_stall,
    input wire [WORD_BITS-1:0]  i_message,
    input wire                  o_valid,
    input wire                  i_stall,
    input wire [WORD_BITS-1:0]  o_result,
    input wire                  i_cfg_valid,
    input wire                  o_cfg_ready,
    input wire [1:0]            i_cfg_index,
    input wire [WORD_BITS-1:0]  i_cfg_data
);

    // A word waiting on the output is not withdrawn while stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result))
        else $error("output word changed while stalled");

    // Only one item is in work: an accepted word closes the input channel.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word accepted while one is in work");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not empty after reset");

endmodule

bind modular_exponentiation_top mexp_checker #(.WORD_BITS(WORD_BITS)) u_mexp_checker (.*);

`default_nettype wire
